### rtl/rgb565_downscale_to_int8_assert.svh
// Assertion macros shared by the downscaler RTL.
`ifndef RGB565_DOWNSCALE_TO_INT8_ASSERT_SVH
`define RGB565_DOWNSCALE_TO_INT8_ASSERT_SVH
`ifndef SYNTH
`define RGBDS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rgbds: assertion failed");
`define RGBDS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rgbds: assertion failed");
`else
`define RGBDS_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define RGBDS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### rtl/rgbds_pkg.sv
package rgbds_pkg;

    localparam int CFG_W       = 11;
    localparam int CFG_INDEX_W = 4;
    localparam int PIXEL_W     = 16;
    localparam int CHAN_W      = 8;
    localparam int FRAC_W      = 16;

    localparam int RESET_SOURCE_DIM = 240;
    localparam int RESET_TARGET_DIM = 160;

    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_WIDTH  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_HEIGHT = 4'd3;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               frame_end;
    } pix_entry_t;

endpackage

### rtl/rgb565_downscale_to_int8.sv
// Nearest-neighbor downscaler from RGB565 to signed 8-bit RGB.
// Source pixels enter in raster order on the s_ channel (s_pixel), one word per
// cycle when s_valid and s_ready are high. Pixels on a chosen row and column
// leave on the m_ channel as red, green and blue values minus 128, with
// m_frame_end set on the last output pixel of a frame.
// The cfg channel writes the source and target sizes by register index; cfg_ready
// is always high and writes are meant to happen with no pixel in flight.
// A kept pixel passes through the queue and then the output register to m_valid;
// one pixel per cycle is sustained while m_ready is high and no division runs.
// After each register write the column and row step ratios are recomputed by two
// bit-serial dividers, one quotient bit per cycle, and s_ready stays low while the
// start strobe, the divisions and their done strobes are pending. New steps apply
// from the next pixel at the start of a frame.
// Reset clears the position counters and loads the steps for 240 by 240 source
// and 160 by 160 target frames. When the receiver stalls, a two-word queue and
// the output register absorb results, then s_ready drops until space frees up.
`include "rgb565_downscale_to_int8_assert.svh"

module rgb565_downscale_to_int8 import rgbds_pkg::*; #(
    parameter int MAX_DIM = 1024
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [PIXEL_W-1:0]       s_pixel,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [CHAN_W-1:0] m_red_value,
    output logic signed [CHAN_W-1:0] m_green_value,
    output logic signed [CHAN_W-1:0] m_blue_value,
    output logic                     m_frame_end,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    localparam int DIM_W  = $clog2(MAX_DIM) + 1;
    localparam int STEP_W = DIM_W + FRAC_W;
    localparam int ACC_W  = STEP_W + DIM_W - 1;

    localparam int RS_SRC  = (RESET_SOURCE_DIM > MAX_DIM) ? MAX_DIM : RESET_SOURCE_DIM;
    localparam int RS_DST0 = (RESET_TARGET_DIM > MAX_DIM) ? MAX_DIM : RESET_TARGET_DIM;
    localparam int RS_DST  = (RS_DST0 > RS_SRC) ? RS_SRC : RS_DST0;
    localparam int RS_STEP = ((RS_SRC << FRAC_W) / RS_DST) + 1;
    localparam logic [STEP_W-1:0] RESET_STEP = STEP_W'(RS_STEP);
    localparam logic [DIM_W-1:0]  RESET_SRC  = DIM_W'(RS_SRC);
    localparam logic [DIM_W-1:0]  RESET_DST  = DIM_W'(RS_DST);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (32'(v) > 32'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    logic [CFG_W-1:0]  src_w_reg, src_h_reg, tgt_w_reg, tgt_h_reg;
    logic [DIM_W-1:0]  eff_sw_reg, eff_sh_reg, eff_tw_reg, eff_th_reg;
    logic [DIM_W-1:0]  sw_next, sh_next, tw0, th0, tw_next, th_next;
    logic              start_reg;
    logic [STEP_W-1:0] pend_col_reg, pend_row_reg;
    logic              col_busy, row_busy, col_done, row_done;
    logic [STEP_W-1:0] col_quo, row_quo;
    logic              cfg_write;
    logic              accept;
    logic              push, q_full, pop, head_valid;
    pix_entry_t        push_entry, head_entry;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg <= CFG_W'(RESET_SOURCE_DIM);
            src_h_reg <= CFG_W'(RESET_SOURCE_DIM);
            tgt_w_reg <= CFG_W'(RESET_TARGET_DIM);
            tgt_h_reg <= CFG_W'(RESET_TARGET_DIM);
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_SOURCE_WIDTH:  src_w_reg <= cfg_data;
                REG_SOURCE_HEIGHT: src_h_reg <= cfg_data;
                REG_TARGET_WIDTH:  tgt_w_reg <= cfg_data;
                REG_TARGET_HEIGHT: tgt_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        sw_next = clamp_dim(src_w_reg);
        sh_next = clamp_dim(src_h_reg);
        tw0     = clamp_dim(tgt_w_reg);
        th0     = clamp_dim(tgt_h_reg);
        tw_next = (tw0 > sw_next) ? sw_next : tw0;
        th_next = (th0 > sh_next) ? sh_next : th0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_sw_reg   <= RESET_SRC;
            eff_sh_reg   <= RESET_SRC;
            eff_tw_reg   <= RESET_DST;
            eff_th_reg   <= RESET_DST;
            start_reg    <= 1'b0;
            pend_col_reg <= RESET_STEP;
            pend_row_reg <= RESET_STEP;
        end else begin
            eff_sw_reg <= sw_next;
            eff_sh_reg <= sh_next;
            eff_tw_reg <= tw_next;
            eff_th_reg <= th_next;
            start_reg  <= cfg_write;
            if (col_done) begin
                pend_col_reg <= col_quo + STEP_W'(1);
            end
            if (row_done) begin
                pend_row_reg <= row_quo + STEP_W'(1);
            end
        end
    end

    rgbds_step_div #(
        .DIVIDEND_W(STEP_W),
        .DIVISOR_W (DIM_W)
    ) u_col_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .dividend({sw_next, {FRAC_W{1'b0}}}),
        .divisor (tw_next),
        .busy    (col_busy),
        .done    (col_done),
        .quotient(col_quo)
    );

    rgbds_step_div #(
        .DIVIDEND_W(STEP_W),
        .DIVISOR_W (DIM_W)
    ) u_row_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .dividend({sh_next, {FRAC_W{1'b0}}}),
        .divisor (th_next),
        .busy    (row_busy),
        .done    (row_done),
        .quotient(row_quo)
    );

    assign s_ready = !(start_reg || col_busy || row_busy || col_done || row_done) && !q_full;
    assign accept  = s_valid && s_ready;

    rgbds_front #(
        .DIM_W     (DIM_W),
        .STEP_W    (STEP_W),
        .ACC_W     (ACC_W),
        .RESET_STEP(RESET_STEP)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .pixel        (s_pixel),
        .eff_sw       (eff_sw_reg),
        .eff_sh       (eff_sh_reg),
        .eff_tw       (eff_tw_reg),
        .eff_th       (eff_th_reg),
        .pend_col_step(pend_col_reg),
        .pend_row_step(pend_row_reg),
        .push         (push),
        .push_entry   (push_entry)
    );

    rgbds_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_entry(push_entry),
        .full      (q_full),
        .pop       (pop),
        .head_valid(head_valid),
        .head_entry(head_entry)
    );

    rgbds_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_red_value  (m_red_value),
        .m_green_value(m_green_value),
        .m_blue_value (m_blue_value),
        .m_frame_end  (m_frame_end)
    );

    `RGBDS_ASSERT_NEXT(a_cfg_blocks_input, aclk, aresetn, cfg_write, !s_ready)
    `RGBDS_ASSERT_IMPL(a_div_blocks_input, aclk, aresetn, col_busy || row_busy, !s_ready)
    `RGBDS_ASSERT_IMPL(a_divs_in_step, aclk, aresetn, 1'b1, col_busy == row_busy)

endmodule

### rtl/rgbds_step_div.sv
module rgbds_step_div #(
    parameter int DIVIDEND_W = 27,
    parameter int DIVISOR_W  = 11
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // One quotient bit per cycle, restoring division.
    always_comb begin
        shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff    = shifted - {1'b0, divisor};
        fits    = !diff[DIVISOR_W];
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            rem_next  = '0;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/rgbds_front.sv
module rgbds_front import rgbds_pkg::*; #(
    parameter int               DIM_W      = 11,
    parameter int               STEP_W     = 27,
    parameter int               ACC_W      = 37,
    parameter logic [STEP_W-1:0] RESET_STEP = 27'd98305
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [PIXEL_W-1:0] pixel,
    input  logic [DIM_W-1:0]  eff_sw,
    input  logic [DIM_W-1:0]  eff_sh,
    input  logic [DIM_W-1:0]  eff_tw,
    input  logic [DIM_W-1:0]  eff_th,
    input  logic [STEP_W-1:0] pend_col_step,
    input  logic [STEP_W-1:0] pend_row_step,
    output logic              push,
    output pix_entry_t        push_entry
);

    localparam int INT_W = ACC_W - FRAC_W;

    logic [DIM_W-1:0]  src_col_reg, src_col_next;
    logic [DIM_W-1:0]  src_row_reg, src_row_next;
    logic [DIM_W-1:0]  out_col_reg, out_col_next;
    logic [DIM_W-1:0]  out_row_reg, out_row_next;
    logic [ACC_W-1:0]  col_acc_reg, col_acc_next;
    logic [ACC_W-1:0]  row_acc_reg, row_acc_next;
    logic [STEP_W-1:0] col_step_reg, col_step_next;
    logic [STEP_W-1:0] row_step_reg, row_step_next;
    logic              at_origin;
    logic              col_hit;
    logic              row_hit;
    logic [DIM_W-1:0]  src_col_inc;
    logic [DIM_W-1:0]  src_row_inc;

    // Steps are reloaded from the latest division results at each frame start.
    always_comb begin
        at_origin     = (src_col_reg == '0) && (src_row_reg == '0);
        col_step_next = at_origin ? pend_col_step : col_step_reg;
        row_step_next = at_origin ? pend_row_step : row_step_reg;
        col_hit = (out_col_reg < eff_tw) &&
                  (col_acc_reg[ACC_W-1:FRAC_W] == INT_W'(src_col_reg));
        row_hit = (out_row_reg < eff_th) &&
                  (row_acc_reg[ACC_W-1:FRAC_W] == INT_W'(src_row_reg));
        src_col_inc = src_col_reg + 1'b1;
        src_row_inc = src_row_reg + 1'b1;
    end

    always_comb begin
        push                 = accept && col_hit && row_hit;
        push_entry.pixel     = pixel;
        push_entry.frame_end = (out_col_reg == eff_tw - 1'b1) &&
                               (out_row_reg == eff_th - 1'b1);
    end

    always_comb begin
        src_col_next = src_col_reg;
        src_row_next = src_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        col_acc_next = col_acc_reg;
        row_acc_next = row_acc_reg;
        if (accept) begin
            if (col_hit) begin
                out_col_next = out_col_reg + 1'b1;
                col_acc_next = col_acc_reg + ACC_W'(col_step_next);
            end
            src_col_next = src_col_inc;
            if (src_col_inc >= eff_sw) begin
                src_col_next = '0;
                out_col_next = '0;
                col_acc_next = '0;
                if (row_hit) begin
                    out_row_next = out_row_reg + 1'b1;
                    row_acc_next = row_acc_reg + ACC_W'(row_step_next);
                end
                src_row_next = src_row_inc;
                if (src_row_inc >= eff_sh) begin
                    src_row_next = '0;
                    out_row_next = '0;
                    row_acc_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_col_reg  <= '0;
            src_row_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            col_acc_reg  <= '0;
            row_acc_reg  <= '0;
            col_step_reg <= RESET_STEP;
            row_step_reg <= RESET_STEP;
        end else begin
            src_col_reg <= src_col_next;
            src_row_reg <= src_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            col_acc_reg <= col_acc_next;
            row_acc_reg <= row_acc_next;
            if (accept) begin
                col_step_reg <= col_step_next;
                row_step_reg <= row_step_next;
            end
        end
    end

endmodule

### rtl/rgbds_queue.sv
`include "rgb565_downscale_to_int8_assert.svh"

module rgbds_queue import rgbds_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  pix_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output pix_entry_t head_entry
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pix_entry_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    `RGBDS_ASSERT_IMPL(a_queue_no_overflow, aclk, aresetn, push, !full)
    `RGBDS_ASSERT_IMPL(a_queue_no_underflow, aclk, aresetn, pop, head_valid)

endmodule

### rtl/rgbds_back.sv
module rgbds_back import rgbds_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     head_valid,
    input  pix_entry_t               head_entry,
    output logic                     pop,
    input  logic                     m_ready,
    output logic                     m_valid,
    output logic signed [CHAN_W-1:0] m_red_value,
    output logic signed [CHAN_W-1:0] m_green_value,
    output logic signed [CHAN_W-1:0] m_blue_value,
    output logic                     m_frame_end
);

    logic                     m_valid_reg, m_valid_next;
    logic signed [CHAN_W-1:0] red_reg;
    logic signed [CHAN_W-1:0] green_reg;
    logic signed [CHAN_W-1:0] blue_reg;
    logic                     frame_end_reg;
    logic [4:0]               red5;
    logic [5:0]               green6;
    logic [4:0]               blue5;
    logic [CHAN_W-1:0]        red8;
    logic [CHAN_W-1:0]        green8;
    logic [CHAN_W-1:0]        blue8;

    // Bit replication to eight bits, then flipping the top bit subtracts 128.
    always_comb begin
        red5   = head_entry.pixel[15:11];
        green6 = head_entry.pixel[10:5];
        blue5  = head_entry.pixel[4:0];
        red8   = {red5, red5[4:2]} ^ 8'h80;
        green8 = {green6, green6[5:4]} ^ 8'h80;
        blue8  = {blue5, blue5[4:2]} ^ 8'h80;
    end

    always_comb begin
        pop          = head_valid && (!m_valid_reg || m_ready);
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            red_reg       <= $signed(red8);
            green_reg     <= $signed(green8);
            blue_reg      <= $signed(blue8);
            frame_end_reg <= head_entry.frame_end;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_red_value   = red_reg;
    assign m_green_value = green_reg;
    assign m_blue_value  = blue_reg;
    assign m_frame_end   = frame_end_reg;

endmodule

### test/tb_rgb565_downscale_to_int8.sv
`timescale 1ns / 100ps

module tb_rgb565_downscale_to_int8;
    import rgbds_pkg::*;

    localparam int MAX_DIM       = 1024;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 500000;

    typedef struct {
        logic signed [CHAN_W-1:0] red;
        logic signed [CHAN_W-1:0] green;
        logic signed [CHAN_W-1:0] blue;
        logic                     frame_end;
    } scaled_pixel_t;

    class downscale_board;
        logic [CFG_W-1:0]  src_w, src_h, dst_w, dst_h;
        int unsigned       src_col, src_row, out_col, out_row;
        longint unsigned   col_acc, row_acc, col_step, row_step;
        scaled_pixel_t     expected_pixels[$];
        int                failures;

        function new();
            src_w = CFG_W'(RESET_SOURCE_DIM);
            src_h = CFG_W'(RESET_SOURCE_DIM);
            dst_w = CFG_W'(RESET_TARGET_DIM);
            dst_h = CFG_W'(RESET_TARGET_DIM);
            src_col = 0;
            src_row = 0;
            out_col = 0;
            out_row = 0;
            col_acc = 0;
            row_acc = 0;
            failures = 0;
            update_steps();
        endfunction

        function int unsigned clamp_dim(logic [CFG_W-1:0] v);
            if (v == 0) return 1;
            if (v > MAX_DIM) return MAX_DIM;
            return v;
        endfunction

        function int unsigned target_dim(logic [CFG_W-1:0] v, int unsigned src);
            int unsigned d;
            d = clamp_dim(v);
            return (d > src) ? src : d;
        endfunction

        function void update_steps();
            longint unsigned sw, sh, tw, th;
            sw = clamp_dim(src_w);
            sh = clamp_dim(src_h);
            tw = target_dim(dst_w, sw);
            th = target_dim(dst_h, sh);
            col_step = (sw << FRAC_W) / tw + 1;
            row_step = (sh << FRAC_W) / th + 1;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] v);
            case (idx)
                REG_SOURCE_WIDTH: src_w = v;
                REG_SOURCE_HEIGHT: src_h = v;
                REG_TARGET_WIDTH: dst_w = v;
                REG_TARGET_HEIGHT: dst_h = v;
                default: ;
            endcase
        endfunction

        function void take_pixel(logic [PIXEL_W-1:0] p);
            int unsigned   sw, sh, tw, th;
            bit            col_hit, row_hit;
            scaled_pixel_t e;
            if (src_col == 0 && src_row == 0) update_steps();
            sw = clamp_dim(src_w);
            sh = clamp_dim(src_h);
            tw = target_dim(dst_w, sw);
            th = target_dim(dst_h, sh);
            col_hit = out_col < tw && (col_acc >> FRAC_W) == src_col;
            row_hit = out_row < th && (row_acc >> FRAC_W) == src_row;
            if (col_hit && row_hit) begin
                e.red = {p[15:11], p[15:13]} ^ 8'h80;
                e.green = {p[10:5], p[10:9]} ^ 8'h80;
                e.blue = {p[4:0], p[4:2]} ^ 8'h80;
                e.frame_end = (out_col == tw - 1) && (out_row == th - 1);
                expected_pixels.push_back(e);
            end
            if (col_hit) begin
                out_col++;
                col_acc += col_step;
            end
            src_col++;
            if (src_col >= sw) begin
                src_col = 0;
                out_col = 0;
                col_acc = 0;
                if (row_hit) begin
                    out_row++;
                    row_acc += row_step;
                end
                src_row++;
                if (src_row >= sh) begin
                    src_row = 0;
                    out_row = 0;
                    row_acc = 0;
                end
            end
        endfunction

        function void compare_field(string name, logic [CHAN_W-1:0] exp_v,
                                    logic [CHAN_W-1:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
                failures++;
            end
        endfunction

        function void check_result(logic signed [CHAN_W-1:0] r, logic signed [CHAN_W-1:0] g,
                                   logic signed [CHAN_W-1:0] b, logic fe);
            scaled_pixel_t e;
            if (expected_pixels.size() == 0) begin
                $error("Output word arrived with no pixel expected.");
                failures++;
                return;
            end
            e = expected_pixels.pop_front();
            compare_field("red_value", e.red, r);
            compare_field("green_value", e.green, g);
            compare_field("blue_value", e.blue, b);
            if (fe !== e.frame_end) begin
                $error("frame_end: expected %0d, got %0d", e.frame_end, fe);
                failures++;
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [PIXEL_W-1:0]        s_pixel = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [CHAN_W-1:0]  m_red_value;
    logic signed [CHAN_W-1:0]  m_green_value;
    logic signed [CHAN_W-1:0]  m_blue_value;
    logic                      m_frame_end;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]          cfg_data = '0;

    downscale_board board;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int cycle_count = 0;
    int sent_random = 0;

    rgb565_downscale_to_int8 #(
        .MAX_DIM(MAX_DIM)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_pixel(s_pixel),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_red_value(m_red_value),
        .m_green_value(m_green_value),
        .m_blue_value(m_blue_value),
        .m_frame_end(m_frame_end),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) board.write_register(cfg_index, cfg_data);
            if (s_valid && s_ready) board.take_pixel(s_pixel);
            if (m_valid && m_ready) begin
                board.check_result(m_red_value, m_green_value, m_blue_value, m_frame_end);
            end
        end
    end

    task automatic set_idling(input int sel);
        case (sel)
            0: begin
                sender_idle_pct = 29;
                receiver_idle_pct = 88;
            end
            1: begin
                sender_idle_pct = 88;
                receiver_idle_pct = 29;
            end
            default: begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
        endcase
    endtask

    task automatic send_pixel(input logic [PIXEL_W-1:0] p);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= p;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_sizes(input logic [CFG_W-1:0] sw, input logic [CFG_W-1:0] sh,
                             input logic [CFG_W-1:0] tw, input logic [CFG_W-1:0] th,
                             input bit stray);
        logic [CFG_INDEX_W-1:0] unused_idx;
        if (stray) begin
            unused_idx = CFG_INDEX_W'($urandom_range(REG_TARGET_HEIGHT + 1, 2**CFG_INDEX_W - 1));
            write_register(unused_idx, CFG_W'($urandom));
        end
        write_register(REG_SOURCE_WIDTH, sw);
        write_register(REG_SOURCE_HEIGHT, sh);
        write_register(REG_TARGET_WIDTH, tw);
        write_register(REG_TARGET_HEIGHT, th);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CFG_W-1:0] sw, sh, tw, th;
        int unsigned      frame_pixels, count;
        board = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        set_idling(0);

        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'hF800);
        send_pixel(16'h07E0);
        send_pixel(16'h001F);
        send_pixel(16'h8410);
        send_pixel(16'h7BEF);
        wait_idle();
        write_register(CFG_INDEX_W'(REG_TARGET_HEIGHT + 1), '1);
        write_register('1, '0);
        cfg_valid <= 1'b0;
        set_sizes('0, '0, '0, '0, 1'b0);
        repeat (3) send_pixel(16'($urandom));
        wait_idle();
        set_sizes(CFG_W'(2), CFG_W'(2), '1, '1, 1'b0);
        repeat (4) send_pixel(16'($urandom));
        wait_idle();
        set_sizes(CFG_W'(3), CFG_W'(2), CFG_W'(1), CFG_W'(1), 1'b0);
        repeat (6) send_pixel(16'($urandom));

        wait_idle();
        set_sizes('1, '1, CFG_W'(MAX_DIM), '1, 1'b1);
        repeat (100) begin
            send_pixel(16'($urandom));
            sent_random++;
        end

        while (sent_random < RANDOM_ITEMS) begin
            set_idling(sent_random * 3 / RANDOM_ITEMS);
            wait_idle();
            if ($urandom_range(0, 9) == 0) begin
                sw = CFG_W'($urandom);
                sh = CFG_W'($urandom);
                tw = CFG_W'($urandom);
                th = CFG_W'($urandom);
            end else begin
                sw = CFG_W'($urandom_range(0, 8));
                sh = CFG_W'($urandom_range(0, 8));
                tw = CFG_W'($urandom_range(0, board.clamp_dim(sw) + 2));
                th = CFG_W'($urandom_range(0, board.clamp_dim(sh) + 2));
            end
            set_sizes(sw, sh, tw, th, $urandom_range(0, 3) == 0);
            frame_pixels = board.clamp_dim(sw) * board.clamp_dim(sh);
            if (frame_pixels <= 64) count = frame_pixels * $urandom_range(1, 3);
            else count = $urandom_range(1, 100);
            repeat (count) begin
                send_pixel(16'($urandom));
                sent_random++;
            end
        end

        wait_idle();
        if (board.failures == 0 && board.pending() == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/rgbds_pkg.sv
rtl/rgbds_step_div.sv
rtl/rgbds_front.sv
rtl/rgbds_queue.sv
rtl/rgbds_back.sv
rtl/rgb565_downscale_to_int8.sv
test/tb_rgb565_downscale_to_int8.sv
